// ===== design/nv3_pkg.sv =====
// ----------------------------------------------------------------------------
// nv3_pkg
// Shared constants for the 3D vector normalizer.
// ----------------------------------------------------------------------------
package nv3_pkg;

    // one divider lane per vector component
    localparam int LANES = 3;

endpackage

// ===== design/nv3_root_step.sv =====
// ----------------------------------------------------------------------------
// nv3_root_step
// One pipelined step of the integer square root: decides one root bit.
// ----------------------------------------------------------------------------
module nv3_root_step #(
    parameter int SUM_W = 48,
    parameter int ROOT_W = 24,
    parameter int BIT = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SUM_W-1:0]  i_rem,
    input  logic [ROOT_W-1:0] i_root,
    output logic [SUM_W-1:0]  o_rem,
    output logic [ROOT_W-1:0] o_root
);

    localparam int CW = SUM_W + 1;
    localparam logic [CW-1:0] BIT_SQ = CW'(1) << (2 * BIT);
    localparam logic [ROOT_W-1:0] BIT_MASK = ROOT_W'(1) << BIT;

    logic [CW-1:0] n_cand;
    logic          n_take;

    // (root + 2^b)^2 - root^2, root holds only bits above b
    assign n_cand = (CW'(i_root) << (BIT + 1)) + BIT_SQ;
    assign n_take = {1'b0, i_rem} >= n_cand;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_take ? (i_rem - n_cand[SUM_W-1:0]) : i_rem;
            o_root <= n_take ? (i_root | BIT_MASK) : i_root;
        end
    end

endmodule

// ===== design/nv3_div_step.sv =====
// ----------------------------------------------------------------------------
// nv3_div_step
// One restoring division step of a lane: yields one quotient bit.
// ----------------------------------------------------------------------------
module nv3_div_step #(
    parameter int COMP_W = 24,
    parameter int QUO_W = 17,
    parameter bit FIRST = 1'b0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [COMP_W:0]   i_part,
    input  logic [COMP_W-1:0] i_div,
    input  logic [QUO_W-1:0]  i_quo,
    output logic [COMP_W:0]   o_part,
    output logic [QUO_W-1:0]  o_quo
);

    logic [COMP_W:0] n_shift;
    logic            n_ge;

    // first step takes the integer bit, later steps bring in a zero
    assign n_shift = FIRST ? i_part : {i_part[COMP_W-1:0], 1'b0};
    assign n_ge    = n_shift >= {1'b0, i_div};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_part <= n_ge ? (n_shift - {1'b0, i_div}) : n_shift;
            o_quo  <= {i_quo[QUO_W-2:0], n_ge};
        end
    end

endmodule

// ===== design/normalize_vector_3d.sv =====
// ----------------------------------------------------------------------------
// normalize_vector_3d
// Scales a signed integer 3D vector to unit length in signed fixed point.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  input     i_valid, o_ready, i_vec_x/y/z             in
//  output    o_valid, i_ready, o_unit_x/y/z,           out
//            o_zero_length
//
//  One word per cycle sustained while i_ready is high. Stages in order:
//  magnitude, square, sum, one stage per root bit, one stage per quotient
//  bit in three divider lanes, then the merge into the output register.
//  Each stage holds its own valid, so bubbles close up under output stall.
//  Synchronous active-low reset clears the valids only.
// ----------------------------------------------------------------------------
module normalize_vector_3d #(
    parameter int COMPONENT_BITS = 24,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COMPONENT_BITS-1:0] i_vec_x,
    input  logic signed [COMPONENT_BITS-1:0] i_vec_y,
    input  logic signed [COMPONENT_BITS-1:0] i_vec_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [FRACTION_BITS+1:0] o_unit_x,
    output logic signed [FRACTION_BITS+1:0] o_unit_y,
    output logic signed [FRACTION_BITS+1:0] o_unit_z,
    output logic                          o_zero_length
);

    localparam int CB    = COMPONENT_BITS;
    localparam int SUM_W = 2 * CB;
    localparam int RW    = CB;
    localparam int QW    = FRACTION_BITS + 1;
    localparam int OW    = FRACTION_BITS + 2;
    localparam int L     = nv3_pkg::LANES;
    localparam int RS    = 2;            // stage of the sum register
    localparam int DS    = RS + RW;      // last root stage; division starts after it
    localparam int NS    = DS + QW + 2;  // total stages incl. output
    localparam int OS    = NS - 1;

    logic [NS-1:0] r_v;
    logic [NS:0]   w_en;

    logic [CB-1:0]    r_mag  [0:DS][L];
    logic [L-1:0]     r_neg  [0:OS-1];
    logic             r_zero [RS:OS-1];
    logic [SUM_W-1:0] r_sq   [L];
    logic [SUM_W-1:0] w_rem  [0:RW];
    logic [RW-1:0]    w_root [0:RW];
    logic [CB-1:0]    w_len  [0:QW-1];
    logic [CB:0]      w_part [0:QW][L];
    logic [QW-1:0]    w_quo  [0:QW][L];
    logic [CB-1:0]    n_mag  [L];
    logic [CB-1:0]    w_in   [L];
    logic [OW-1:0]    n_unit [L];

    // ---- flow control: a stage advances when empty or its successor moves
    assign w_en[NS] = i_ready;
    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_en
            assign w_en[k] = !r_v[k] || w_en[k+1];
        end
    endgenerate
    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // ---- magnitude and sign
    assign w_in[0] = i_vec_x;
    assign w_in[1] = i_vec_y;
    assign w_in[2] = i_vec_z;

    always_comb begin
        for (int c = 0; c < L; c++) begin
            n_mag[c] = w_in[c][CB-1] ? (~w_in[c] + CB'(1)) : w_in[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int c = 0; c < L; c++) begin
                r_mag[0][c] <= n_mag[c];
                r_neg[0][c] <= w_in[c][CB-1];
            end
        end
    end

    // ---- squares, one multiplier per lane
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int c = 0; c < L; c++) begin
                r_sq[c] <= SUM_W'(r_mag[0][c]) * SUM_W'(r_mag[0][c]);
            end
        end
    end

    // ---- sum of squares, seeds the root
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    assign n_sum = r_sq[0] + r_sq[1] + r_sq[2];

    always_ff @(posedge i_clk) begin
        if (w_en[RS]) begin
            r_sum        <= n_sum;
            r_zero[RS]   <= (n_sum == '0);
        end
    end

    assign w_rem[0]  = r_sum;
    assign w_root[0] = '0;

    // ---- sideband carry: magnitudes, signs, zero flag
    generate
        for (k = 1; k <= DS; k++) begin : g_mag
            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_mag[k] <= r_mag[k-1];
                end
            end
        end
        for (k = 1; k < OS; k++) begin : g_neg
            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_neg[k] <= r_neg[k-1];
                end
            end
        end
        for (k = RS + 1; k < OS; k++) begin : g_zero
            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_zero[k] <= r_zero[k-1];
                end
            end
        end
    endgenerate

    // ---- square root, one bit per stage
    generate
        for (k = 0; k < RW; k++) begin : g_root
            nv3_root_step #(
                .SUM_W (SUM_W),
                .ROOT_W(RW),
                .BIT   (RW - 1 - k)
            ) u_step (
                .i_clk (i_clk),
                .i_en  (w_en[RS+1+k]),
                .i_rem (w_rem[k]),
                .i_root(w_root[k]),
                .o_rem (w_rem[k+1]),
                .o_root(w_root[k+1])
            );
        end
    endgenerate

    // ---- divider lanes, divisor carried alongside
    assign w_len[0] = w_root[RW];
    generate
        for (k = 1; k < QW; k++) begin : g_len
            logic [CB-1:0] r_len;
            always_ff @(posedge i_clk) begin
                if (w_en[DS+k]) begin
                    r_len <= w_len[k-1];
                end
            end
            assign w_len[k] = r_len;
        end

        genvar c;
        for (c = 0; c < L; c++) begin : g_lane
            assign w_part[0][c] = {1'b0, r_mag[DS][c]};
            assign w_quo[0][c]  = '0;
            for (k = 0; k < QW; k++) begin : g_step
                nv3_div_step #(
                    .COMP_W(CB),
                    .QUO_W (QW),
                    .FIRST (k == 0)
                ) u_step (
                    .i_clk (i_clk),
                    .i_en  (w_en[DS+1+k]),
                    .i_part(w_part[k][c]),
                    .i_div (w_len[k]),
                    .i_quo (w_quo[k][c]),
                    .o_part(w_part[k+1][c]),
                    .o_quo (w_quo[k+1][c])
                );
            end
        end
    endgenerate

    // ---- merge: apply signs, force zero for the null vector
    always_comb begin
        for (int c = 0; c < L; c++) begin
            if (r_zero[OS-1]) begin
                n_unit[c] = '0;
            end else if (r_neg[OS-1][c]) begin
                n_unit[c] = OW'(0) - {1'b0, w_quo[QW][c]};
            end else begin
                n_unit[c] = {1'b0, w_quo[QW][c]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[OS]) begin
            o_unit_x      <= n_unit[0];
            o_unit_y      <= n_unit[1];
            o_unit_z      <= n_unit[2];
            o_zero_length <= r_zero[OS-1];
        end
    end

    assign o_valid = r_v[OS];

`ifndef NO_ASSERTIONS
    localparam logic signed [OW-1:0] UNIT_ONE = OW'(1) << FRACTION_BITS;

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_length |-> o_unit_x == '0 && o_unit_y == '0 && o_unit_z == '0)
        else $error("zero vector with nonzero unit components");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_unit_x <= UNIT_ONE && o_unit_x >= -UNIT_ONE
                 && o_unit_y <= UNIT_ONE && o_unit_y >= -UNIT_ONE
                 && o_unit_z <= UNIT_ONE && o_unit_z >= -UNIT_ONE)
        else $error("unit component beyond one");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule
